@@ src/humidity_sensor_frame_decoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder assertion macros
// Concurrent assertion wrappers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH
`define HSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HSFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define HSFD_ASSERT(lbl, prop, msg)
`define HSFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

`endif

@@ src/hsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder package
// Beat types, status codes, frame constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package hsfd_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  HdrFunc  = 8'h03;
  localparam logic [7:0]  HdrCount = 8'h04;
  localparam logic [14:0] MagMask  = 15'h7FFF;

  localparam logic [2:0] PosFunc   = 3'd0;
  localparam logic [2:0] PosCount  = 3'd1;
  localparam logic [2:0] PosHumHi  = 3'd2;
  localparam logic [2:0] PosHumLo  = 3'd3;
  localparam logic [2:0] PosTempHi = 3'd4;
  localparam logic [2:0] PosTempLo = 3'd5;
  localparam logic [2:0] PosCrcLo  = 3'd6;
  localparam logic [2:0] PosCrcHi  = 3'd7;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadHeader = 2'd1,
    StatusBadCrc    = 2'd2
  } hsfd_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } hsfd_in_t;

  typedef struct packed {
    hsfd_status_e       status;
    logic signed [15:0] temperature_tenths;
    logic [15:0]        humidity_tenths;
  } hsfd_out_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/humidity_sensor_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder
// Checks an eight-byte sensor response (header, CRC-16/MODBUS) and decodes
// humidity and signed temperature in tenths.
// ----------------------------------------------------------------------------
// A result beat is loaded into the output register when the last frame byte leaves the input register.
// Throughput: one byte per cycle; input register feeds the frame logic, which
// writes the output register; a result beat held by the receiver stalls input.
// Reset: asynchronous, active low; clears both valids and restarts the frame.
`include "humidity_sensor_frame_decoder_unit_macros.svh"

module humidity_sensor_frame_decoder_unit import hsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hsfd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hsfd_out_t out_data_o
);

  logic      s1_valid_q, s1_valid_d;
  hsfd_in_t  s1_q;
  logic      s1_fire;
  logic      out_valid_q, out_valid_d;
  hsfd_out_t out_q;
  logic      emit;
  hsfd_out_t result;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  hsfd_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .beat_i   (s1_q),
    .emit_o   (emit),
    .result_o (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (s1_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HSFD_ASSERT(a_s1_hold, s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_q),
               "input stage lost a stalled beat")
  `HSFD_ASSERT(a_ready_stall, !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i,
               "input stalled without output backpressure")
  `HSFD_ASSERT_CLK(a_out_from_emit, clk_i, rst_ni,
                   $rose(out_valid_o) |-> $past(s1_fire && emit),
                   "result beat without last frame byte")

endmodule

@@ src/hsfd_frame.sv @@
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder: frame tracker
// Byte position, running CRC, header check and field collection per beat.
// ----------------------------------------------------------------------------
`include "humidity_sensor_frame_decoder_unit_macros.svh"

module hsfd_frame import hsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  hsfd_in_t  beat_i,
  output logic      emit_o,
  output hsfd_out_t result_o
);

  logic [2:0]  pos_q, pos_d, pos;
  logic [15:0] crc_q, crc_d, crc_base, crc_new, received;
  logic        hdr_q, hdr_d, hdr_base;
  logic [15:0] hum_q, hum_d;
  logic [15:0] temp_q, temp_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  b;

  assign b        = beat_i.rx_byte;
  assign pos      = beat_i.frame_start ? PosFunc : pos_q;
  assign crc_base = beat_i.frame_start ? CrcInit : crc_q;
  assign hdr_base = beat_i.frame_start ? 1'b1 : hdr_q;
  assign crc_new  = crc_feed(crc_base, b);
  assign received = {b, crc_lo_q};

  always_comb begin
    pos_d    = pos + 3'd1;
    crc_d    = crc_base;
    hdr_d    = hdr_base;
    hum_d    = hum_q;
    temp_d   = temp_q;
    crc_lo_d = crc_lo_q;
    emit_o   = 1'b0;
    result_o = '{status: StatusOk, temperature_tenths: 16'sd0, humidity_tenths: 16'd0};
    unique case (pos)
      PosFunc: begin
        crc_d = crc_new;
        hdr_d = hdr_base & (b == HdrFunc);
      end
      PosCount: begin
        crc_d = crc_new;
        hdr_d = hdr_base & (b == HdrCount);
      end
      PosHumHi: begin
        crc_d = crc_new;
        hum_d = {b, hum_q[7:0]};
      end
      PosHumLo: begin
        crc_d = crc_new;
        hum_d = {hum_q[15:8], b};
      end
      PosTempHi: begin
        crc_d  = crc_new;
        temp_d = {b, temp_q[7:0]};
      end
      PosTempLo: begin
        crc_d  = crc_new;
        temp_d = {temp_q[15:8], b};
      end
      PosCrcLo: begin
        crc_lo_d = b;
      end
      default: begin
        emit_o = 1'b1;
        pos_d  = PosFunc;
        crc_d  = CrcInit;
        hdr_d  = 1'b1;
        if (!hdr_base) begin
          result_o.status = StatusBadHeader;
        end else if (received != crc_base) begin
          result_o.status = StatusBadCrc;
        end else begin
          result_o.humidity_tenths = hum_q;
          if (temp_q[15]) begin
            result_o.temperature_tenths = -$signed({1'b0, temp_q[14:0] & MagMask});
          end else begin
            result_o.temperature_tenths = $signed(temp_q);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosFunc;
      crc_q    <= CrcInit;
      hdr_q    <= 1'b1;
      hum_q    <= 16'd0;
      temp_q   <= 16'd0;
      crc_lo_q <= 8'd0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      hdr_q    <= hdr_d;
      hum_q    <= hum_d;
      temp_q   <= temp_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  `HSFD_ASSERT(a_emit_restarts, fire_i && emit_o |=> pos_q == PosFunc && crc_q == CrcInit && hdr_q, "frame state not restarted after last byte")
  `HSFD_ASSERT(a_err_zero_fields, emit_o && result_o.status != StatusOk |-> result_o.temperature_tenths == 16'sd0 && result_o.humidity_tenths == 16'd0, "error result carries data")
  `HSFD_ASSERT(a_no_start_emit, beat_i.frame_start |-> !emit_o, "result on first byte of frame")

endmodule

@@ sim/hsfd_checker.sv @@
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder checker
// Watches both beat channels and predicts each response frame's status,
// humidity and temperature from the accepted input bytes. It compares every
// result beat with the oldest pending prediction and counts failures.
// ----------------------------------------------------------------------------
module hsfd_checker import hsfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  hsfd_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  hsfd_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]  slot;
  logic [15:0] crc_acc;
  logic        hdr_ok;
  logic [15:0] hum_word;
  logic [15:0] temp_word;
  logic [7:0]  crc_lo;
  hsfd_out_t   frame_q[$];
  int          n_fail = 0;

  // bitwise CRC-16/MODBUS, data LSB first
  function automatic logic [15:0] modbus_crc_step(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) r = r ^ 16'hA001;
    end
    return r;
  endfunction

  task automatic restart_frame();
    slot    = PosFunc;
    crc_acc = 16'hFFFF;
    hdr_ok  = 1'b1;
  endtask

  task automatic decode_beat(input hsfd_in_t beat);
    hsfd_out_t   res;
    logic [15:0] rx_crc;
    logic [7:0]  b;
    b = beat.rx_byte;
    if (beat.frame_start) restart_frame();
    if (slot < PosCrcLo) crc_acc = modbus_crc_step(crc_acc, b);
    case (slot)
      PosFunc:   if (b != 8'h03) hdr_ok = 1'b0;
      PosCount:  if (b != 8'h04) hdr_ok = 1'b0;
      PosHumHi:  hum_word[15:8] = b;
      PosHumLo:  hum_word[7:0] = b;
      PosTempHi: temp_word[15:8] = b;
      PosTempLo: temp_word[7:0] = b;
      PosCrcLo:  crc_lo = b;
      default: begin
        rx_crc = {b, crc_lo};
        res    = '0;
        if (!hdr_ok) begin
          res.status = StatusBadHeader;
        end else if (rx_crc != crc_acc) begin
          res.status = StatusBadCrc;
        end else begin
          res.status = StatusOk;
          // sign-magnitude to two's complement; 0x8000 maps to 0
          if (temp_word[15]) res.temperature_tenths = 16'h0000 - {1'b0, temp_word[14:0]};
          else               res.temperature_tenths = temp_word;
          res.humidity_tenths = hum_word;
        end
        frame_q.push_back(res);
      end
    endcase
    if (slot == PosCrcHi) restart_frame();
    else                  slot = slot + 3'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hsfd_out_t exp_res;
    if (!rst_ni) begin
      restart_frame();
      hum_word  = '0;
      temp_word = '0;
      crc_lo    = '0;
      frame_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) decode_beat(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (frame_q.size() == 0) begin
          $error("result beat with no frame pending: status %0d temp %0d hum %0d",
                 out_data_i.status, out_data_i.temperature_tenths,
                 out_data_i.humidity_tenths);
          n_fail++;
        end else begin
          exp_res = frame_q.pop_front();
          if (out_data_i.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_data_i.status);
            n_fail++;
          end
          if (out_data_i.temperature_tenths !== exp_res.temperature_tenths) begin
            $error("temperature_tenths: expected %0d, got %0d",
                   exp_res.temperature_tenths, out_data_i.temperature_tenths);
            n_fail++;
          end
          if (out_data_i.humidity_tenths !== exp_res.humidity_tenths) begin
            $error("humidity_tenths: expected %0d, got %0d",
                   exp_res.humidity_tenths, out_data_i.humidity_tenths);
            n_fail++;
          end
        end
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= frame_q.size();
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Humidity sensor frame decoder testbench
// Sends directed and random sensor response frames (good, bad header, bad
// CRC, truncated, noise) with random gaps and receiver stalls, including one
// long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb import hsfd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeats   = 1950;
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int TailCycles    = 10;

  typedef enum int {FrGood, FrBadHdr, FrBadCrc, FrBoth} frame_kind_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  hsfd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hsfd_out_t out_data;
  int        fail_count;
  int        pending;
  int        beats_sent = 0;
  int        quiet = 0;
  bit        steady = 1'b0;
  bit        held_off = 1'b0;

  always #5 clk_i = ~clk_i;

  humidity_sensor_frame_decoder_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  hsfd_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 4) != 0) return 16'($urandom);
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'h8001;
      default: return 16'h0001;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic [7:0] b, input logic start);
    int n;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_start: start};
    do @(posedge clk_i); while (!in_ready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [15:0] hum,
                            input logic [15:0] temp, input logic flag, input int len);
    logic [7:0]  fb[8];
    logic [15:0] crc;
    int          idx;
    fb[0] = HdrFunc;
    fb[1] = HdrCount;
    fb[2] = hum[15:8];
    fb[3] = hum[7:0];
    fb[4] = temp[15:8];
    fb[5] = temp[7:0];
    idx = $urandom_range(0, 1);
    if (kind == FrBadHdr) fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
    crc = CrcInit;
    for (int i = 0; i < 6; i++) crc = crc_feed(crc, fb[i]);
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    if (kind == FrBoth) fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
    if (kind == FrBadCrc) begin
      idx = $urandom_range(6, 7);
      fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < len; i++) send_beat(fb[i], flag && (i == 0));
  endtask

  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++) send_beat(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else                                                   quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, steady stretches and one long hold-off
  initial begin
    int n;
    repeat (3) @(negedge clk_i);
    forever begin
      n = gap_len();
      if (!held_off && beats_sent >= 600) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 150)) @(negedge clk_i);
      else                           repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin
    int          r;
    int          directed;
    frame_kind_e kind;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_frame(FrGood, 16'hFFFF, 16'h8000, 1'b1, 8);  // negative zero
    send_frame(FrGood, 16'h1234, 16'h0101, 1'b1, 3);  // cut short by next start
    send_frame(FrGood, 16'h0000, 16'hFFFF, 1'b1, 8);  // most negative
    send_frame(FrBoth, 16'h7FFF, 16'h7FFF, 1'b0, 8);  // no start flag, both checks bad
    directed = beats_sent;

    while (beats_sent < directed + RandomBeats) begin
      r = $urandom_range(0, 99);
      steady = ($urandom_range(0, 3) == 0);
      if      (r < 62) kind = FrGood;
      else if (r < 74) kind = FrBadCrc;
      else if (r < 84) kind = FrBadHdr;
      else             kind = FrBoth;
      if (r < 88)      send_frame(kind, pick_word(), pick_word(),
                                  $urandom_range(0, 9) != 0, 8);
      else if (r < 95) send_frame(FrGood, pick_word(), pick_word(), 1'b1,
                                  $urandom_range(1, 7));
      else             send_noise($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/hsfd_pkg.sv
src/hsfd_frame.sv
src/humidity_sensor_frame_decoder_unit.sv
sim/hsfd_checker.sv
sim/tb.sv
